[hw/rtl/base64_stream_codec_core_defines.svh]
// Assertion macros shared by the codec RTL.
// All checks are sampled on the rising clock edge.
// All checks are disabled while the synchronous reset is held.
`ifndef BASE64_STREAM_CODEC_CORE_DEFINES_SVH
`define BASE64_STREAM_CODEC_CORE_DEFINES_SVH

// Property that must hold whenever reset is released.
`define B64SC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true.
`define B64SC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/b64sc_pkg.sv]
`timescale 1ns / 1ps

package b64sc_pkg;

    // Most result words that one input word can produce.
    localparam int MaxResults = 4;
    localparam int CountWidth = $clog2(MaxResults + 1);

    // Mode register values.
    localparam logic ModeEncode = 1'b0;
    localparam logic ModeDecode = 1'b1;

    // Character constants.
    localparam logic [7:0] PadChar = 8'h3D;
    localparam logic [7:0] InvalidCode = 8'hFF;
    localparam logic [7:0] PadCode = 8'h40;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_error;
        logic       out_last;
    } t_out_word;

    // Codec state carried from word to word.
    typedef struct packed {
        logic [1:0] group_phase;
        logic [5:0] carry_bits;
        logic       error_seen;
        logic       padding_seen;
    } t_codec_state;

    // Results of one input word, handed to the output stage.
    typedef struct packed {
        logic [CountWidth-1:0]           count;
        t_out_word [MaxResults-1:0]      words;
    } t_result_group;

    // Six-bit value to alphabet character.
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26) begin
                c = 8'h41 + {2'b00, v};
            end else if (v < 6'd52) begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end else if (v < 6'd62) begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end else if (v == 6'd62) begin
                c = 8'h2B;
            end else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

    // Character to six-bit value, pad code or invalid code.
    function automatic logic [7:0] b64_char_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h41 && c <= 8'h5A) begin
                v = c - 8'h41;
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                v = c - 8'h61 + 8'd26;
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30 + 8'd52;
            end else if (c == 8'h2B) begin
                v = 8'd62;
            end else if (c == 8'h2F) begin
                v = 8'd63;
            end else if (c == PadChar) begin
                v = PadCode;
            end else begin
                v = InvalidCode;
            end
            return v;
        end
    endfunction

endpackage

[hw/rtl/b64sc_step.sv]
`timescale 1ns / 1ps

module b64sc_step
    import b64sc_pkg::*;
(
    input  logic          i_mode,
    input  t_codec_state  i_state,
    input  t_in_word      i_word,
    output t_codec_state  o_state,
    output t_result_group o_group
);

    logic [7:0]          b;
    logic [7:0]          v;
    logic [1:0]          ph;
    logic [5:0]          c;
    t_codec_state        ns;
    t_out_word [MaxResults-1:0] w;
    logic [CountWidth-1:0] n;

    assign b  = i_word.in_byte;
    assign v  = b64_char_value(b);
    assign ph = i_state.group_phase;
    assign c  = i_state.carry_bits;

    // One codec step: next state and up to four result words.
    always_comb begin
        ns = i_state;
        w  = '0;
        n  = '0;
        if (i_mode == ModeEncode) begin
            case (ph)
                2'd1: begin
                    w[0].out_byte = b64_symbol(c | {2'b00, b[7:4]});
                    ns.carry_bits = {b[3:0], 2'b00};
                    ns.group_phase = 2'd2;
                    n = CountWidth'(1);
                end
                2'd2: begin
                    w[0].out_byte = b64_symbol(c | {4'b0000, b[7:6]});
                    w[1].out_byte = b64_symbol(b[5:0]);
                    ns.carry_bits = '0;
                    ns.group_phase = 2'd0;
                    n = CountWidth'(2);
                end
                default: begin
                    w[0].out_byte = b64_symbol(b[7:2]);
                    ns.carry_bits = {b[1:0], 4'b0000};
                    ns.group_phase = 2'd1;
                    n = CountWidth'(1);
                end
            endcase
            // Flush leftover bits and pad the message to whole groups.
            if (i_word.in_last) begin
                if (ns.group_phase == 2'd1) begin
                    w[1].out_byte = b64_symbol(ns.carry_bits);
                    w[2].out_byte = PadChar;
                    w[3].out_byte = PadChar;
                    n = CountWidth'(4);
                end else if (ns.group_phase == 2'd2) begin
                    w[1].out_byte = b64_symbol(ns.carry_bits);
                    w[2].out_byte = PadChar;
                    n = CountWidth'(3);
                end
                for (int k = 0; k < MaxResults; k++) begin
                    if (n == CountWidth'(k + 1)) begin
                        w[k].out_last = 1'b1;
                    end
                end
                ns = '0;
            end
        end else begin
            if (!i_state.error_seen) begin
                if (v == InvalidCode) begin
                    ns.error_seen = 1'b1;
                end else if (v == PadCode) begin
                    // Padding is only legal in the last two places of a group.
                    if (ph < 2'd2) begin
                        ns.error_seen = 1'b1;
                    end else begin
                        ns.padding_seen = 1'b1;
                        ns.group_phase = ph + 2'd1;
                    end
                end else if (i_state.padding_seen) begin
                    ns.error_seen = 1'b1;
                end else begin
                    case (ph)
                        2'd0: begin
                            ns.carry_bits = v[5:0];
                        end
                        2'd1: begin
                            w[0].out_byte = {c, v[5:4]};
                            ns.carry_bits = {2'b00, v[3:0]};
                            n = CountWidth'(1);
                        end
                        2'd2: begin
                            w[0].out_byte = {c[3:0], v[5:2]};
                            ns.carry_bits = {4'b0000, v[1:0]};
                            n = CountWidth'(1);
                        end
                        default: begin
                            w[0].out_byte = {c[1:0], v[5:0]};
                            ns.carry_bits = '0;
                            n = CountWidth'(1);
                        end
                    endcase
                    ns.group_phase = ph + 2'd1;
                end
            end
            // The final word always closes with exactly one last result.
            if (i_word.in_last) begin
                if (ns.error_seen || ns.group_phase != 2'd0) begin
                    w = '0;
                    w[0].out_error = 1'b1;
                    w[0].out_last = 1'b1;
                end else begin
                    w[0].out_last = 1'b1;
                end
                n = CountWidth'(1);
                ns = '0;
            end
        end
    end

    assign o_state       = ns;
    assign o_group.count = n;
    assign o_group.words = w;

endmodule

[hw/rtl/b64sc_emit.sv]
`timescale 1ns / 1ps

`include "base64_stream_codec_core_defines.svh"

module b64sc_emit
    import b64sc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result_group i_group,
    output logic          o_free,
    output logic          o_out_valid,
    output t_out_word     o_out_word,
    input  logic          i_out_stall
);

    localparam int IdxWidth = $clog2(MaxResults);

    t_out_word [MaxResults-1:0] r_words;
    logic [CountWidth-1:0]      r_cnt;
    logic [IdxWidth-1:0]        r_idx;
    logic                       take;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_words[r_idx];
    assign take        = o_out_valid && !i_out_stall;

    // The group register can be refilled once its final word leaves.
    assign o_free = (r_cnt == '0) || (r_cnt == CountWidth'(1) && take);

    // Result group register, drained one word per cycle while the output is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load && o_free) begin
            r_cnt <= i_group.count;
            r_idx <= '0;
        end else if (take) begin
            r_cnt <= r_cnt - CountWidth'(1);
            r_idx <= r_idx + IdxWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_words <= i_group.words;
        end
    end

    `B64SC_ASSERT_NEVER(a_cnt_range, r_cnt > CountWidth'(MaxResults), "result count overflow")
    `B64SC_ASSERT(a_last_ends_group, (o_out_valid && o_out_word.out_last) |-> (r_cnt == CountWidth'(1)), "last flag before end of group")
    `B64SC_ASSERT(a_hold_on_stall, (o_out_valid && i_out_stall) |=> ($stable(r_idx) && $stable(r_cnt)), "group advanced while stalled")
    `B64SC_ASSERT(a_load_when_free, i_load |-> o_free, "group loaded over pending words")

endmodule

[hw/rtl/base64_stream_codec_core.sv]
`timescale 1ns / 1ps

// Streaming Base64 codec (standard alphabet, '=' padding). Words enter an input
// register at up to one per cycle while the input is not stalled; one step of
// combinational logic turns the registered word into a group of zero to four
// result words, which a group register then sends out at one word per cycle
// while the output is not stalled. The output sets the rate: a word waits in
// the input register until the group register has sent out the previous
// group, and the input stalls meanwhile. The mode register (0 encode, 1
// decode) is to be written by the user through the configuration channel only
// while the codec is idle; the block does not enforce this. A write also
// clears the message state.
module base64_stream_codec_core
    import b64sc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic          r_mode;
    t_codec_state  r_state;
    logic          r_in_valid;
    t_in_word      r_in_word;
    t_codec_state  n_state;
    t_result_group step_group;
    logic          emit_free;
    logic          advance;
    logic          in_take;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && emit_free;
    assign o_in_stall  = r_in_valid && !emit_free;
    assign in_take     = i_in_valid && !o_in_stall;

    // Mode register and codec state; state moves as each word is processed and clears on a mode write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ModeEncode;
            r_state <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode  <= i_cfg_data;
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    b64sc_step u_step (
        .i_mode  (r_mode),
        .i_state (r_state),
        .i_word  (r_in_word),
        .o_state (n_state),
        .o_group (step_group)
    );

    b64sc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_group     (step_group),
        .o_free      (emit_free),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule
